### hdl/gbm_path_step_with_basket_payoff_top_assert.svh
// ----------------------------------------------------------------------------
// GBM path step assertion macros
// Concurrent assertion wrappers, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef GBM_PATH_STEP_WITH_BASKET_PAYOFF_TOP_ASSERT_SVH
`define GBM_PATH_STEP_WITH_BASKET_PAYOFF_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define GBM_ASSERT_IMP(lbl, ck, rn, pre, post, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) else $error(msg);
`define GBM_ASSERT_NXT(lbl, ck, rn, pre, post, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) else $error(msg);
`else
`define GBM_ASSERT_IMP(lbl, ck, rn, pre, post, msg)
`define GBM_ASSERT_NXT(lbl, ck, rn, pre, post, msg)
`endif
`endif

### hdl/gbm_pkg.sv
// ----------------------------------------------------------------------------
// GBM path step package
// Shared constants, types and tables of the GBM path step block.
// ----------------------------------------------------------------------------
`default_nettype none
package gbm_pkg;
  localparam int ASSETS = 4;
  localparam int AW     = 2;
  localparam int MW     = 37;
  localparam int PW     = 2 * MW;
  localparam int XW     = 48;
  localparam int EXP_TERMS = 10;
  localparam logic [28:0] LOG2E_Q28 = 29'd387270501;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic signed [XW-1:0] XLIM = 48'sh20_0000_0000;

  typedef enum logic [2:0] {
    REG_VOL, REG_RATE, REG_DIV, REG_DT, REG_SQDT, REG_STRIKE, REG_KIND, REG_LEN
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_A_SG2, S_A_DRIFT, S_A_W, S_A_DIFF, S_A_X,
    S_P_MIN, S_P_STEP, S_P_X,
    S_E_X, S_E_Y, S_E_G, S_E_TQ, S_E_TR, S_E_TC, S_E_TM, S_E_V, S_E_SH,
    S_DONE
  } seq_state_t;

  // floor(2^35 / i) for the series term division
  function automatic logic [35:0] recip_q35(input logic [3:0] i);
    logic [35:0] r;
    begin
      case (i)
        4'd2:    r = 36'd17179869184;
        4'd3:    r = 36'd11453246122;
        4'd4:    r = 36'd8589934592;
        4'd5:    r = 36'd6871947673;
        4'd6:    r = 36'd5726623061;
        4'd7:    r = 36'd4908534052;
        4'd8:    r = 36'd4294967296;
        4'd9:    r = 36'd3817748707;
        4'd10:   r = 36'd3435973836;
        default: r = 36'd34359738368;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

### hdl/gbm_mul.sv
// ----------------------------------------------------------------------------
// GBM shared multiplier
// Signed multiplier with registered product, shared by the sequencer steps that multiply.
// ----------------------------------------------------------------------------
`default_nettype none
module gbm_mul (
  input  wire logic                           clk,
  input  wire logic signed [gbm_pkg::MW-1:0]  mul_a,
  input  wire logic signed [gbm_pkg::MW-1:0]  mul_b,
  output logic signed      [gbm_pkg::PW-1:0]  prod_r
);
  import gbm_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end
endmodule
`default_nettype wire

### hdl/gbm_path_step_with_basket_payoff_top.sv
// ----------------------------------------------------------------------------
// GBM path step with basket payoff
// Starts a path or advances its four asset prices one exact GBM step, and
// gives the discounted minimum put or maximum call payoff for every beat.
// ----------------------------------------------------------------------------
// One beat at a time. A shared multiplier under a sequencer evaluates every
// exponential as range reduction plus a ten term series. An advance beat
// runs four price updates and then the discount; a start or a rejected
// advance runs the discount alone. The input is stalled while a beat is in
// work; a finished beat waits in the output register while the next input
// beat is taken.
`default_nettype none
`include "gbm_path_step_with_basket_payoff_top_assert.svh"
module gbm_path_step_with_basket_payoff_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_start_path,
  input  wire logic [9:0]  in_start_step,
  input  wire logic [31:0] in_spot_0,
  input  wire logic [31:0] in_spot_1,
  input  wire logic [31:0] in_spot_2,
  input  wire logic [31:0] in_spot_3,
  input  wire logic signed [15:0] in_noise_0,
  input  wire logic signed [15:0] in_noise_1,
  input  wire logic signed [15:0] in_noise_2,
  input  wire logic signed [15:0] in_noise_3,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [9:0]       out_step_index,
  output logic [31:0]      out_price_0,
  output logic [31:0]      out_price_1,
  output logic [31:0]      out_price_2,
  output logic [31:0]      out_price_3,
  output logic [31:0]      out_discounted_payoff,
  output logic             out_last_step,
  output logic             out_step_rejected
);
  import gbm_pkg::*;

  // configuration
  logic [63:0] vol_r;
  logic [15:0] rate_r, div_r, dt_r, sqdt_r;
  logic [31:0] strike_r;
  logic        kind_r;
  logic [10:0] len_r;
  logic        cfg_wr;
  cfg_reg_t    cfg_idx;

  // path state and working registers
  seq_state_t        state_r, state_nxt;
  logic [31:0]       price_r [ASSETS];
  logic [31:0]       price_nxt [ASSETS];
  logic signed [15:0] noise_r [ASSETS];
  logic [9:0]        cur_r, cur_nxt;
  logic              active_r, active_nxt;
  logic              reject_r, reject_nxt;
  logic              ex_asset_r, ex_asset_nxt;
  logic [AW-1:0]     asset_r, asset_nxt;
  logic signed [XW-1:0] x_r, x_nxt;
  logic [31:0]       v_r, v_nxt;
  logic signed [7:0] n_r, n_nxt;
  logic [29:0]       g_r, g_nxt;
  logic [30:0]       term_r, term_nxt, t_r, t_nxt, q_r, q_nxt;
  logic [31:0]       sum_r, sum_nxt;
  logic [3:0]        i_r, i_nxt;
  logic [31:0]       pay_r, pay_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;

  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_r;

  // datapath temporaries
  logic [10:0]          len_eff;
  logic                 in_take;
  logic                 can_adv;
  logic [15:0]          sg;
  logic signed [16:0]   rd17;
  logic signed [PW-1:0] sh15, sh11;
  logic signed [XW-1:0] xc, xq;
  logic [31:0]          lo, hi, pay_raw;
  logic [30:0]          rem;
  logic [30:0]          qf;
  logic signed [8:0]    s9;
  logic [8:0]           ns9;
  logic [63:0]          pr64, r64;
  logic [95:0]          w96;
  logic [31:0]          res;

  gbm_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // APB
  assign pready  = 1'b1;
  assign cfg_idx = cfg_reg_t'(paddr[5:3]);
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    case (cfg_idx)
      REG_VOL:    prdata = vol_r;
      REG_RATE:   prdata = {48'd0, rate_r};
      REG_DIV:    prdata = {48'd0, div_r};
      REG_DT:     prdata = {48'd0, dt_r};
      REG_SQDT:   prdata = {48'd0, sqdt_r};
      REG_STRIKE: prdata = {32'd0, strike_r};
      REG_KIND:   prdata = {63'd0, kind_r};
      REG_LEN:    prdata = {53'd0, len_r};
      default:    prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_r    <= 64'd0;
      rate_r   <= 16'd0;
      div_r    <= 16'd0;
      dt_r     <= 16'd0;
      sqdt_r   <= 16'd0;
      strike_r <= 32'd0;
      kind_r   <= 1'b0;
      len_r    <= 11'd2;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_VOL:    vol_r    <= pwdata;
        REG_RATE:   rate_r   <= pwdata[15:0];
        REG_DIV:    div_r    <= pwdata[15:0];
        REG_DT:     dt_r     <= pwdata[15:0];
        REG_SQDT:   sqdt_r   <= pwdata[15:0];
        REG_STRIKE: strike_r <= pwdata[31:0];
        REG_KIND:   kind_r   <= pwdata[0];
        REG_LEN:    len_r    <= pwdata[10:0];
        default:    ;
      endcase
    end
  end

  assign len_eff = (len_r < 11'd2) ? 11'd2 : ((len_r > 11'd1024) ? 11'd1024 : len_r);
  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid & ~in_stall;
  assign can_adv   = active_r & (({1'b0, cur_r} + 11'd1) < len_eff);
  assign out_load  = (state_r == S_DONE) & (~out_valid_r | ~out_stall);
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_start_path || !can_adv) state_nxt = S_P_MIN;
          else                           state_nxt = S_A_SG2;
        end
      end
      S_A_SG2:   state_nxt = S_A_DRIFT;
      S_A_DRIFT: state_nxt = S_A_W;
      S_A_W:     state_nxt = S_A_DIFF;
      S_A_DIFF:  state_nxt = S_A_X;
      S_A_X:     state_nxt = S_E_X;
      S_P_MIN:   state_nxt = S_P_STEP;
      S_P_STEP:  state_nxt = S_P_X;
      S_P_X:     state_nxt = S_E_X;
      S_E_X:     state_nxt = S_E_Y;
      S_E_Y:     state_nxt = S_E_G;
      S_E_G:     state_nxt = S_E_TQ;
      S_E_TQ:    state_nxt = (i_r == 4'd1) ? S_E_TM : S_E_TR;
      S_E_TR:    state_nxt = S_E_TC;
      S_E_TC:    state_nxt = (i_r == 4'(EXP_TERMS)) ? S_E_V : S_E_TM;
      S_E_TM:    state_nxt = S_E_TQ;
      S_E_V:     state_nxt = S_E_SH;
      S_E_SH: begin
        if (!ex_asset_r)                           state_nxt = S_DONE;
        else if (asset_r == AW'(ASSETS - 1))       state_nxt = S_P_MIN;
        else                                       state_nxt = S_A_SG2;
      end
      S_DONE:    if (out_load) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    for (int d = 0; d < ASSETS; d++) price_nxt[d] = price_r[d];
    cur_nxt       = cur_r;
    active_nxt    = active_r;
    reject_nxt    = reject_r;
    ex_asset_nxt  = ex_asset_r;
    asset_nxt     = asset_r;
    x_nxt         = x_r;
    v_nxt         = v_r;
    n_nxt         = n_r;
    g_nxt         = g_r;
    term_nxt      = term_r;
    t_nxt         = t_r;
    q_nxt         = q_r;
    sum_nxt       = sum_r;
    i_nxt         = i_r;
    pay_nxt       = pay_r;
    out_valid_nxt = out_valid_r;
    mul_a         = '0;
    mul_b         = '0;

    sg   = vol_r[16 * asset_r +: 16];
    rd17 = {rate_r[15], rate_r} - {div_r[15], div_r};
    sh15 = prod_r >>> 15;
    sh11 = prod_r >>> 11;
    xc   = (x_r > XLIM) ? XLIM : ((x_r < -XLIM) ? -XLIM : x_r);
    xq   = xc >>> 4;
    lo   = price_r[0];
    hi   = price_r[0];
    for (int d = 1; d < ASSETS; d++) begin
      if (price_r[d] < lo) lo = price_r[d];
      if (price_r[d] > hi) hi = price_r[d];
    end
    if (kind_r) pay_raw = (hi > strike_r) ? hi - strike_r : 32'd0;
    else        pay_raw = (strike_r > lo) ? strike_r - lo : 32'd0;
    rem  = t_r - prod_r[30:0];
    qf   = (rem >= {27'd0, i_r}) ? q_r + 31'd1 : q_r;
    s9   = 9'sd30 - {n_r[7], n_r};
    ns9  = 9'd0 - s9;
    pr64 = prod_r[63:0];
    r64  = pr64 >> s9[5:0];
    w96  = {32'd0, pr64} << ns9[4:0];
    if (s9 >= 9'sd64)      res = 32'd0;
    else if (s9 >= 9'sd0)  res = (|r64[63:32]) ? 32'hFFFF_FFFF : r64[31:0];
    else if (ns9 >= 9'd32) res = (pr64 == 64'd0) ? 32'd0 : 32'hFFFF_FFFF;
    else                   res = (|w96[95:32]) ? 32'hFFFF_FFFF : w96[31:0];

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          asset_nxt = '0;
          if (in_start_path) begin
            price_nxt[0] = in_spot_0;
            price_nxt[1] = in_spot_1;
            price_nxt[2] = in_spot_2;
            price_nxt[3] = in_spot_3;
            cur_nxt      = in_start_step;
            active_nxt   = 1'b1;
            reject_nxt   = 1'b0;
          end else begin
            reject_nxt = ~can_adv;
          end
        end
      end
      S_A_SG2: begin
        ex_asset_nxt = 1'b1;
        mul_a = $signed({21'd0, sg});
        mul_b = $signed({21'd0, sg});
      end
      S_A_DRIFT: begin
        mul_a = ($signed({{20{rd17[16]}}, rd17}) <<< 17) - $signed({5'd0, prod_r[31:0]});
        mul_b = $signed({21'd0, dt_r});
      end
      S_A_W: begin
        x_nxt = sh15[XW-1:0];
        mul_a = $signed({21'd0, sqdt_r});
        mul_b = $signed({{21{noise_r[asset_r][15]}}, noise_r[asset_r]});
      end
      S_A_DIFF: begin
        mul_a = $signed({21'd0, sg});
        mul_b = prod_r[MW-1:0];
      end
      S_A_X: begin
        x_nxt = x_r + sh11[XW-1:0];
        v_nxt = price_r[asset_r];
      end
      S_P_MIN: begin
        ex_asset_nxt = 1'b0;
        v_nxt = pay_raw;
        mul_a = $signed({{21{rate_r[15]}}, rate_r});
        mul_b = $signed({21'd0, dt_r});
      end
      S_P_STEP: begin
        mul_a = prod_r[MW-1:0];
        mul_b = $signed({27'd0, cur_r});
      end
      S_P_X: begin
        x_nxt = ($signed(48'd0) - prod_r[XW-1:0]) <<< 2;
      end
      S_E_X: begin
        mul_a = xq[MW-1:0];
        mul_b = $signed({8'd0, LOG2E_Q28});
      end
      S_E_Y: begin
        n_nxt = prod_r[63:56];
        mul_a = $signed({5'd0, prod_r[55:24]});
        mul_b = $signed({7'd0, LN2_Q30});
      end
      S_E_G: begin
        g_nxt    = prod_r[61:32];
        term_nxt = ONE_Q30;
        sum_nxt  = {1'b0, ONE_Q30};
        i_nxt    = 4'd1;
        mul_a    = $signed({6'd0, ONE_Q30});
        mul_b    = $signed({7'd0, prod_r[61:32]});
      end
      S_E_TQ: begin
        t_nxt = prod_r[60:30];
        if (i_r == 4'd1) begin
          term_nxt = prod_r[60:30];
          sum_nxt  = sum_r + {1'b0, prod_r[60:30]};
          i_nxt    = 4'd2;
        end else begin
          mul_a = $signed({6'd0, prod_r[60:30]});
          mul_b = $signed({1'b0, recip_q35(i_r)});
        end
      end
      S_E_TR: begin
        q_nxt = prod_r[65:35];
        mul_a = $signed({6'd0, prod_r[65:35]});
        mul_b = $signed({33'd0, i_r});
      end
      S_E_TC: begin
        term_nxt = qf;
        sum_nxt  = sum_r + {1'b0, qf};
        i_nxt    = i_r + 4'd1;
      end
      S_E_TM: begin
        mul_a = $signed({6'd0, term_r});
        mul_b = $signed({7'd0, g_r});
      end
      S_E_V: begin
        mul_a = $signed({5'd0, v_r});
        mul_b = $signed({5'd0, sum_r});
      end
      S_E_SH: begin
        if (ex_asset_r) begin
          price_nxt[asset_r] = res;
          asset_nxt = asset_r + AW'(1);
          if (asset_r == AW'(ASSETS - 1)) cur_nxt = cur_r + 10'd1;
        end else begin
          pay_nxt = res;
        end
      end
      S_DONE: begin
        if (out_load) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= 10'd0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int d = 0; d < ASSETS; d++) price_r[d] <= 32'd0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      for (int d = 0; d < ASSETS; d++) price_r[d] <= price_nxt[d];
    end
  end

  always_ff @(posedge clk) begin
    reject_r   <= reject_nxt;
    ex_asset_r <= ex_asset_nxt;
    asset_r    <= asset_nxt;
    x_r        <= x_nxt;
    v_r        <= v_nxt;
    n_r        <= n_nxt;
    g_r        <= g_nxt;
    term_r     <= term_nxt;
    t_r        <= t_nxt;
    q_r        <= q_nxt;
    sum_r      <= sum_nxt;
    i_r        <= i_nxt;
    pay_r      <= pay_nxt;
    if (in_take) begin
      noise_r[0] <= in_noise_0;
      noise_r[1] <= in_noise_1;
      noise_r[2] <= in_noise_2;
      noise_r[3] <= in_noise_3;
    end
    if (out_load) begin
      out_step_index        <= cur_r;
      out_price_0           <= price_r[0];
      out_price_1           <= price_r[1];
      out_price_2           <= price_r[2];
      out_price_3           <= price_r[3];
      out_discounted_payoff <= pay_r;
      out_last_step         <= ({1'b0, cur_r} == (len_eff - 11'd1));
      out_step_rejected     <= reject_r;
    end
  end

  `GBM_ASSERT_NXT(a_take_busy, clk, rst_n, in_take, state_r != S_IDLE, "beat not started")
  `GBM_ASSERT_IMP(a_term_idx, clk, rst_n, (state_r == S_E_TQ) || (state_r == S_E_TC), (i_r >= 4'd1) && (i_r <= 4'(EXP_TERMS)), "series index out of range")
  `GBM_ASSERT_NXT(a_reject_hold, clk, rst_n, (state_r == S_P_MIN) && reject_r, $stable(cur_r), "rejected beat moved step")
  `GBM_ASSERT_IMP(a_done_pending, clk, rst_n, (state_r == S_DONE) && out_valid_r && out_stall, !out_load, "result overwritten")
endmodule
`default_nettype wire
